[design/bpld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpld_pkg;

   localparam int unsigned TickWidth      = 8;
   localparam int unsigned CsrIndexWidth  = 3;
   localparam int unsigned PhaseCodeWidth = 3;
   // longest chain in one tick: release debounce, idle, press debounce, pressed, long
   localparam int unsigned PassLimit      = 5;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_PDEB    = 5'b00010,
      PH_PRESSED = 5'b00100,
      PH_LONG    = 5'b01000,
      PH_RDEB    = 5'b10000
   } phase_type;

   localparam logic [PhaseCodeWidth-1:0] PHASE_CODE_IDLE    = 3'd0;
   localparam logic [PhaseCodeWidth-1:0] PHASE_CODE_PDEB    = 3'd1;
   localparam logic [PhaseCodeWidth-1:0] PHASE_CODE_PRESSED = 3'd2;
   localparam logic [PhaseCodeWidth-1:0] PHASE_CODE_LONG    = 3'd3;
   localparam logic [PhaseCodeWidth-1:0] PHASE_CODE_RDEB    = 3'd4;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ACTIVE_LEVEL      = 3'd0,
      CSR_DEBOUNCE_TICKS    = 3'd1,
      CSR_LONG_PRESS_TICKS  = 3'd2,
      CSR_REPEAT_TICKS      = 3'd3,
      CSR_PRESS_ENABLE      = 3'd4,
      CSR_LONG_PRESS_ENABLE = 3'd5,
      CSR_RELEASE_ENABLE    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                 active_level;
      logic [TickWidth-1:0] debounce_ticks;
      logic [TickWidth-1:0] long_press_ticks;
      logic [TickWidth-1:0] repeat_ticks;
      logic                 press_enable;
      logic                 long_press_enable;
      logic                 release_enable;
   } cfg_type;

   typedef struct packed {
      logic                      press_event;
      logic                      long_press_event;
      logic                      release_event;
      logic [PhaseCodeWidth-1:0] phase_code;
   } rsp_type;

   function automatic logic [PhaseCodeWidth-1:0] phase_code_of(input phase_type ph);
      logic [PhaseCodeWidth-1:0] code;
      unique case (ph)
         PH_PDEB:    code = PHASE_CODE_PDEB;
         PH_PRESSED: code = PHASE_CODE_PRESSED;
         PH_LONG:    code = PHASE_CODE_LONG;
         PH_RDEB:    code = PHASE_CODE_RDEB;
         default:    code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[design/bpld_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpld_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink (input valid, input pin_level, output ready);
endinterface

`default_nettype wire

[design/bpld_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpld_rsp_if import bpld_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      press_event;
   logic                      long_press_event;
   logic                      release_event;
   logic [PhaseCodeWidth-1:0] phase_code;

   modport source (
      output valid, output press_event, output long_press_event,
      output release_event, output phase_code, input ready
   );
   modport sink (
      input valid, input press_event, input long_press_event,
      input release_event, input phase_code, output ready
   );
endinterface

`default_nettype wire

[design/bpld_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpld_csr_if import bpld_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [TickWidth-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[design/button_press_long_press_detector.sv]
`timescale 1ns / 1ps
`default_nettype none

// Button poller: every req word is one poll tick with the sampled pin level, and
// every tick gives exactly one rsp word with press, long-press and release flags
// (each gated by its enable) plus the phase reached after the tick. A new word is
// taken every cycle while the output is not stalled; a word's result passes
// through an input register and a result register, and the phase chain of one tick
// is settled combinationally between them. Debounce, long-press and repeat limits
// are latched when a phase is entered, so writes reach the count at the next phase
// entry; active level and the repeat-off check act at once. The csr port is always
// ready; write it only while no word is in flight. Unknown register indexes are
// ignored.
module button_press_long_press_detector import bpld_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bpld_req_if.sink          req_bus,
   bpld_rsp_if.source        rsp_bus,
   bpld_csr_if.sink          csr_bus
);

   cfg_type cfg;
   rsp_type core_rsp;
   rsp_type rsp_word_ff, rsp_word_in;
   logic    in_valid_ff, in_valid_in;
   logic    pin_ff, pin_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    req_take;

   assign csr_bus.ready = 1'b1;

   bpld_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   assign advance       = in_valid_ff & (~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_take      = req_bus.valid & req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign pin_in = req_take ? req_bus.pin_level : pin_ff;

   bpld_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .pin_level (pin_ff),
      .cfg       (cfg),
      .result    (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_word_in = advance ? core_rsp : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_ff      <= pin_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.press_event      = rsp_word_ff.press_event;
   assign rsp_bus.long_press_event = rsp_word_ff.long_press_event;
   assign rsp_bus.release_event    = rsp_word_ff.release_event;
   assign rsp_bus.phase_code       = rsp_word_ff.phase_code;

endmodule

`default_nettype wire

[design/bpld_csr.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpld_csr import bpld_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CsrIndexWidth-1:0] wr_index,
   input  logic [TickWidth-1:0]     wr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_ACTIVE_LEVEL:      cfg_in.active_level      = wr_data[0];
            CSR_DEBOUNCE_TICKS:    cfg_in.debounce_ticks    = wr_data;
            CSR_LONG_PRESS_TICKS:  cfg_in.long_press_ticks  = wr_data;
            CSR_REPEAT_TICKS:      cfg_in.repeat_ticks      = wr_data;
            CSR_PRESS_ENABLE:      cfg_in.press_enable      = wr_data[0];
            CSR_LONG_PRESS_ENABLE: cfg_in.long_press_enable = wr_data[0];
            CSR_RELEASE_ENABLE:    cfg_in.release_enable    = wr_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/bpld_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpld_core import bpld_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    pin_level,
   input  cfg_type cfg,
   output rsp_type result
);

   typedef struct packed {
      phase_type            phase;
      logic [TickWidth-1:0] count;
      logic [TickWidth-1:0] limit;
   } ctx_type;

   ctx_type ctx_ff, ctx_in, ctx_walk;
   logic    held;
   logic    again;
   logic    ev_press;
   logic    ev_long;
   logic    ev_release;

   assign held = (pin_level == cfg.active_level);

   // phase changes chain within one tick until a phase waits
   always_comb begin
      ctx_walk   = ctx_ff;
      again      = 1'b1;
      ev_press   = 1'b0;
      ev_long    = 1'b0;
      ev_release = 1'b0;
      for (int step_idx = 0; step_idx < PassLimit; step_idx++) begin
         if (again) begin
            again = 1'b0;
            unique case (ctx_walk.phase)
               PH_PDEB: begin
                  if (ctx_walk.count >= ctx_walk.limit) begin
                     ctx_walk.phase = PH_PRESSED;
                     ctx_walk.count = '0;
                     ctx_walk.limit = cfg.long_press_ticks;
                     again          = 1'b1;
                  end else begin
                     ctx_walk.count = ctx_walk.count + 1'b1;
                  end
               end
               PH_PRESSED: begin
                  if (!held) begin
                     ctx_walk.phase = PH_RDEB;
                     ctx_walk.count = '0;
                     ctx_walk.limit = cfg.debounce_ticks;
                     ev_release     = 1'b1;
                     again          = 1'b1;
                  end else if (ctx_walk.count >= ctx_walk.limit) begin
                     ctx_walk.phase = PH_LONG;
                     ctx_walk.count = '0;
                     ctx_walk.limit = cfg.repeat_ticks;
                     ev_long        = 1'b1;
                     again          = 1'b1;
                  end else begin
                     ctx_walk.count = ctx_walk.count + 1'b1;
                  end
               end
               PH_LONG: begin
                  if (!held) begin
                     ctx_walk.phase = PH_RDEB;
                     ctx_walk.count = '0;
                     ctx_walk.limit = cfg.debounce_ticks;
                     ev_release     = 1'b1;
                     again          = 1'b1;
                  end else if (cfg.repeat_ticks != '0) begin
                     if (ctx_walk.count >= ctx_walk.limit) begin
                        ctx_walk.count = '0;
                        ev_long        = 1'b1;
                     end else begin
                        ctx_walk.count = ctx_walk.count + 1'b1;
                     end
                  end
               end
               PH_RDEB: begin
                  if (ctx_walk.count >= ctx_walk.limit) begin
                     ctx_walk.phase = PH_IDLE;
                     again          = 1'b1;
                  end else begin
                     ctx_walk.count = ctx_walk.count + 1'b1;
                  end
               end
               default: begin
                  if (held) begin
                     ctx_walk.phase = PH_PDEB;
                     ctx_walk.count = '0;
                     ctx_walk.limit = cfg.debounce_ticks;
                     ev_press       = 1'b1;
                     again          = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   assign ctx_in = step ? ctx_walk : ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.phase <= PH_IDLE;
         ctx_ff.count <= '0;
         ctx_ff.limit <= '0;
      end else begin
         ctx_ff <= ctx_in;
      end
   end

   assign result.press_event      = ev_press & cfg.press_enable;
   assign result.long_press_event = ev_long & cfg.long_press_enable;
   assign result.release_event    = ev_release & cfg.release_enable;
   assign result.phase_code       = phase_code_of(ctx_walk.phase);

`ifndef NO_ASSERTIONS
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(ctx_ff.phase))
      else $error("phase register lost its one-hot code");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(ctx_ff))
      else $error("phase state moved without a word");

   a_press_lands_held: assert property (@(posedge clock) disable iff (reset)
      (step && ev_press) |-> (held && (ctx_walk.phase == PH_PDEB
         || ctx_walk.phase == PH_PRESSED || ctx_walk.phase == PH_LONG)))
      else $error("press event without a held phase");

   a_release_lands_free: assert property (@(posedge clock) disable iff (reset)
      (step && ev_release) |-> (!held && (ctx_walk.phase == PH_RDEB
         || ctx_walk.phase == PH_IDLE)))
      else $error("release event without a released phase");

   a_long_lands_long: assert property (@(posedge clock) disable iff (reset)
      (step && ev_long) |-> (ctx_walk.phase == PH_LONG))
      else $error("long-press event outside the long phase");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import bpld_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int ChainLimit = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpld_req_if req_bus();
   bpld_rsp_if rsp_bus();
   bpld_csr_if csr_bus();

   button_press_long_press_detector dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   // register shadow and button phase tracker
   cfg_type                   csr_shadow;
   logic [PhaseCodeWidth-1:0] track_phase;
   logic [TickWidth-1:0]      track_count;
   logic [TickWidth-1:0]      track_limit;

   rsp_type awaited_rsp[$];
   rsp_type due_word;

   int  error_count   = 0;
   int  ticks_sent    = 0;
   int  csr_writes    = 0;
   int  press_seen    = 0;
   int  long_seen     = 0;
   int  release_seen  = 0;
   int  rsp_hold_left = 0;
   bit  gaps_on       = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void apply_reg(input logic [CsrIndexWidth-1:0] idx,
                                     input logic [TickWidth-1:0] data);
      case (idx)
         CSR_ACTIVE_LEVEL:      csr_shadow.active_level      = data[0];
         CSR_DEBOUNCE_TICKS:    csr_shadow.debounce_ticks    = data;
         CSR_LONG_PRESS_TICKS:  csr_shadow.long_press_ticks  = data;
         CSR_REPEAT_TICKS:      csr_shadow.repeat_ticks      = data;
         CSR_PRESS_ENABLE:      csr_shadow.press_enable      = data[0];
         CSR_LONG_PRESS_ENABLE: csr_shadow.long_press_enable = data[0];
         CSR_RELEASE_ENABLE:    csr_shadow.release_enable    = data[0];
         default: ;
      endcase
   endfunction

   function automatic void enter_phase(input logic [PhaseCodeWidth-1:0] code,
                                       input logic [TickWidth-1:0] limit);
      track_phase = code;
      track_count = '0;
      track_limit = limit;
   endfunction

   function automatic rsp_type predict_tick(input logic pin);
      rsp_type word;
      logic    held, ev_press, ev_long, ev_release, again;
      int      pass;
      held       = (pin == csr_shadow.active_level);
      ev_press   = 1'b0;
      ev_long    = 1'b0;
      ev_release = 1'b0;
      again      = 1'b1;
      pass       = 0;
      // phase changes chain within one tick
      while (again && pass < ChainLimit) begin
         again = 1'b0;
         case (track_phase)
            PHASE_CODE_PDEB: begin
               if (track_count >= track_limit) begin
                  enter_phase(PHASE_CODE_PRESSED, csr_shadow.long_press_ticks);
                  again = 1'b1;
               end else begin
                  track_count++;
               end
            end
            PHASE_CODE_PRESSED: begin
               if (!held) begin
                  enter_phase(PHASE_CODE_RDEB, csr_shadow.debounce_ticks);
                  ev_release = 1'b1;
                  again      = 1'b1;
               end else if (track_count >= track_limit) begin
                  enter_phase(PHASE_CODE_LONG, csr_shadow.repeat_ticks);
                  ev_long = 1'b1;
                  again   = 1'b1;
               end else begin
                  track_count++;
               end
            end
            PHASE_CODE_LONG: begin
               if (!held) begin
                  enter_phase(PHASE_CODE_RDEB, csr_shadow.debounce_ticks);
                  ev_release = 1'b1;
                  again      = 1'b1;
               end else if (csr_shadow.repeat_ticks != 0) begin
                  if (track_count >= track_limit) begin
                     track_count = '0;
                     ev_long     = 1'b1;
                  end else begin
                     track_count++;
                  end
               end
            end
            PHASE_CODE_RDEB: begin
               if (track_count >= track_limit) begin
                  track_phase = PHASE_CODE_IDLE;
                  again       = 1'b1;
               end else begin
                  track_count++;
               end
            end
            default: begin
               if (held) begin
                  enter_phase(PHASE_CODE_PDEB, csr_shadow.debounce_ticks);
                  ev_press = 1'b1;
                  again    = 1'b1;
               end
            end
         endcase
         pass++;
      end
      word.press_event      = ev_press & csr_shadow.press_enable;
      word.long_press_event = ev_long & csr_shadow.long_press_enable;
      word.release_event    = ev_release & csr_shadow.release_enable;
      word.phase_code       = (track_phase <= PHASE_CODE_RDEB) ? track_phase
                                                               : PHASE_CODE_IDLE;
      return word;
   endfunction

   task automatic send_tick(input logic pin, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pin_level <= pin;
      do @(posedge clock); while (!req_bus.ready);
      awaited_rsp.push_back(predict_tick(pin));
      ticks_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [TickWidth-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_reg(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_all(input logic active, input logic [TickWidth-1:0] deb,
                          input logic [TickWidth-1:0] lng, input logic [TickWidth-1:0] rep,
                          input logic pe, input logic le, input logic re);
      write_reg(CSR_ACTIVE_LEVEL, {7'd0, active});
      write_reg(CSR_DEBOUNCE_TICKS, deb);
      write_reg(CSR_LONG_PRESS_TICKS, lng);
      write_reg(CSR_REPEAT_TICKS, rep);
      write_reg(CSR_PRESS_ENABLE, {7'd0, pe});
      write_reg(CSR_LONG_PRESS_ENABLE, {7'd0, le});
      write_reg(CSR_RELEASE_ENABLE, {7'd0, re});
   endtask

   // alternating held / released runs with some bounce mixed in
   task automatic press_sequences(input int count, input int max_run);
      int   sent, run;
      logic press_next, lvl;
      sent       = 0;
      press_next = 1'b1;
      while (sent < count) begin
         if ($urandom_range(0, 4) == 0) begin
            send_tick(1'($urandom_range(0, 1)), pick_gap());
            sent++;
         end else begin
            lvl = press_next ? csr_shadow.active_level : ~csr_shadow.active_level;
            run = $urandom_range(1, max_run);
            repeat (run) send_tick(lvl, pick_gap());
            sent       += run;
            press_next = ~press_next;
         end
      end
   endtask

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("rsp word with nothing expected");
            error_count++;
         end else begin
            due_word = awaited_rsp.pop_front();
            if (rsp_bus.press_event !== due_word.press_event) begin
               $error("press_event: expected %0b, got %0b",
                      due_word.press_event, rsp_bus.press_event);
               error_count++;
            end
            if (rsp_bus.long_press_event !== due_word.long_press_event) begin
               $error("long_press_event: expected %0b, got %0b",
                      due_word.long_press_event, rsp_bus.long_press_event);
               error_count++;
            end
            if (rsp_bus.release_event !== due_word.release_event) begin
               $error("release_event: expected %0b, got %0b",
                      due_word.release_event, rsp_bus.release_event);
               error_count++;
            end
            if (rsp_bus.phase_code !== due_word.phase_code) begin
               $error("phase_code: expected %0d, got %0d",
                      due_word.phase_code, rsp_bus.phase_code);
               error_count++;
            end
            press_seen   += due_word.press_event;
            long_seen    += due_word.long_press_event;
            release_seen += due_word.release_event;
         end
      end
   end

   // result side ready with stalls and long hold-offs
   initial begin
      int stall;
      stall         = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold_left--;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic test_reset_state();
      // all registers zero: low level counts as pressed, every flag masked
      send_tick(1'b1, 0);
      send_tick(1'b0, 0);
      send_tick(1'b0, 1);
      send_tick(1'b1, 0);
      wait_idle();
   endtask

   task automatic test_register_map();
      write_reg(CSR_ACTIVE_LEVEL, 8'hFE);
      write_reg(CSR_PRESS_ENABLE, 8'hFF);
      write_reg(CSR_LONG_PRESS_ENABLE, 8'hAB);
      write_reg(CSR_RELEASE_ENABLE, 8'h55);
      write_reg(CSR_DEBOUNCE_TICKS, 8'hFF);
      write_reg(CSR_DEBOUNCE_TICKS, 8'h00);
      write_reg(CSR_LONG_PRESS_TICKS, 8'h00);
      write_reg(CSR_REPEAT_TICKS, 8'h00);
      // unused index must not disturb anything
      write_reg(CSR_UNUSED_INDEX, 8'hFF);
      send_tick(1'b0, 0);
      send_tick(1'b1, 0);
      send_tick(1'b0, 0);
      wait_idle();
   endtask

   task automatic test_press_long_repeat();
      set_all(1'b1, 8'd1, 8'd2, 8'd1, 1'b1, 1'b1, 1'b1);
      repeat (7) send_tick(1'b1, 0);
      repeat (3) send_tick(1'b0, 0);
      wait_idle();
   endtask

   task automatic test_repeat_reenable();
      // zero limits pass straight to long pressed in one tick
      set_all(1'b1, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 0);
      send_tick(1'b1, 0);
      wait_idle();
      write_reg(CSR_REPEAT_TICKS, 8'd3);
      repeat (3) send_tick(1'b1, 0);
      send_tick(1'b0, 0);
      wait_idle();
   endtask

   task automatic test_disabled_events();
      set_all(1'b1, 8'd0, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
      repeat (3) send_tick(1'b1, 0);
      send_tick(1'b0, 0);
      wait_idle();
   endtask

   task automatic test_random_settings();
      gaps_on = 1'b1;
      set_all(1'b1, 8'd1, 8'd3, 8'd2, 1'b1, 1'b1, 1'b1);
      press_sequences(60, 10);
      wait_idle();
      set_all(1'b0, 8'd0, 8'd0, 8'd0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
      press_sequences(40, 6);
      wait_idle();
      repeat (4) begin
         set_all(1'($urandom_range(0, 1)), 8'($urandom_range(0, 4)),
                 8'($urandom_range(0, 5)), 8'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
         press_sequences(20, 12);
         wait_idle();
         // live repeat change while the button may still be held
         write_reg(CSR_REPEAT_TICKS, 8'($urandom_range(0, 2)));
         press_sequences(10, 8);
         wait_idle();
      end
      // a stretch without any idling
      gaps_on = 1'b0;
      set_all(1'($urandom_range(0, 1)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
              8'($urandom_range(1, 3)), 1'b1, 1'b1, 1'b1);
      press_sequences(40, 9);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      gaps_on = 1'b0;
      set_all(1'b1, 8'd1, 8'd2, 8'd1, 1'b1, 1'b1, 1'b1);
      rsp_hold_left = 150;
      press_sequences(40, 8);
      wait_idle();
   endtask

   task automatic test_extreme_limits();
      // longest debounce into long press, release left counting its debounce
      gaps_on = 1'b1;
      set_all(1'b1, 8'hFF, 8'h01, 8'hFF, 1'b1, 1'b1, 1'b1);
      repeat (262) send_tick(1'b1, pick_gap());
      repeat (4) send_tick(1'b0, pick_gap());
      wait_idle();
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.pin_level = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.wdata     = '0;
      csr_shadow        = '0;
      track_phase       = PHASE_CODE_IDLE;
      track_count       = '0;
      track_limit       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_map();
      test_press_long_repeat();
      test_repeat_reenable();
      test_disabled_events();
      test_random_settings();
      test_output_backpressure();
      test_extreme_limits();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("summary: %0d poll ticks checked across %0d register writes",
               ticks_sent, csr_writes);
      $display("summary: %0d press, %0d long-press, %0d release flags observed",
               press_seen, long_seen, release_seen);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #4800000;
      $display("timeout");
      $display("testbench: done, errors");
      $finish;
   end

endmodule
